FILE: rtl/core/s2x_pkg.sv
`default_nettype none

package s2x_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_PIXEL_BITS = 24;

   localparam int WIDTH_W = 11;
   localparam int HEIGHT_W = 12;
   localparam int ROW_W = 12;
   localparam int COL_W = 10;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_DRAIN = 1'b1
   } command_type;

endpackage

`default_nettype wire

FILE: rtl/core/s2x_line_store.sv
`default_nettype none

module s2x_line_store #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 24
) (
   input  wire logic                      clock,
   input  wire logic                      rd_en,
   input  wire logic                      rd_bank,
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr_e,
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr_f,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire logic [DATA_W-1:0]         wr_data,
   output logic      [DATA_W-1:0]         e_data,
   output logic      [DATA_W-1:0]         f_data,
   output logic      [DATA_W-1:0]         b_data
);

   // Bank rd_bank holds the row being expanded, the other bank the row above it.
   // Writes always go to the other bank, after its old entry has been read.
   logic [DATA_W-1:0] bank0_mem [DEPTH];
   logic [DATA_W-1:0] bank1_mem [DEPTH];

   logic [DATA_W-1:0] e0_ff;
   logic [DATA_W-1:0] f0_ff;
   logic [DATA_W-1:0] e1_ff;
   logic [DATA_W-1:0] f1_ff;
   logic              bank_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         e0_ff <= bank0_mem[rd_addr_e];
         f0_ff <= bank0_mem[rd_addr_f];
      end
      if (wr_en && rd_bank) begin
         bank0_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         e1_ff <= bank1_mem[rd_addr_e];
         f1_ff <= bank1_mem[rd_addr_f];
      end
      if (wr_en && !rd_bank) begin
         bank1_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         bank_ff <= rd_bank;
      end
   end

   assign e_data = bank_ff ? e1_ff : e0_ff;
   assign f_data = bank_ff ? f1_ff : f0_ff;
   assign b_data = bank_ff ? e0_ff : e1_ff;

endmodule

`default_nettype wire

FILE: rtl/core/scale2x_pixel_upscaler.sv
// Channel  Direction  Handshake              Beat
// req      in         req_valid/req_ready    command, source pixel
// rsp      out        rsp_valid/rsp_ready    position and 2x2 output block
// csr      in/out     psel/penable/pready    image_width, image_height
//
// One beat is taken every cycle unless a stalled result holds stage one.
// The line store is read at each beat taken and written at each pixel taken.
// A stalled result holds the output register; one more fills stage one.
// Reset is synchronous; the line store has no reset and no clearing pass.
`default_nettype none

module scale2x_pixel_upscaler #(
   parameter int MAX_WIDTH  = s2x_pkg::DEF_MAX_WIDTH,
   parameter int PIXEL_BITS = s2x_pkg::DEF_PIXEL_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_command,
   input  wire logic [PIXEL_BITS-1:0]             req_pixel,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [s2x_pkg::ROW_W-1:0]         rsp_src_row,
   output logic      [s2x_pkg::COL_W-1:0]         rsp_src_col,
   output logic      [PIXEL_BITS-1:0]             rsp_top_left,
   output logic      [PIXEL_BITS-1:0]             rsp_top_right,
   output logic      [PIXEL_BITS-1:0]             rsp_bottom_left,
   output logic      [PIXEL_BITS-1:0]             rsp_bottom_right,
   output logic                                   rsp_frame_end,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [s2x_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [s2x_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [s2x_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                   pready
);

   import s2x_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int MWW = $clog2(MAX_WIDTH + 1);
   localparam int WW  = (MWW > WIDTH_W) ? MWW : WIDTH_W;
   localparam int CXW = (CW > COL_W) ? CW : COL_W;

   // Configuration registers.
   logic [WIDTH_W-1:0]  image_width_ff;
   logic [WIDTH_W-1:0]  image_width_in;
   logic [HEIGHT_W-1:0] image_height_ff;
   logic [HEIGHT_W-1:0] image_height_in;
   logic                csr_write;
   reg_index_type       csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_W-1]);

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  image_width_in  = pwdata[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: image_height_in = pwdata[HEIGHT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_W'(image_width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_W'(image_height_ff);
      endcase
   end

   // Frame position state.
   logic [ROW_W-1:0] row_count_ff;
   logic [ROW_W-1:0] row_count_in;
   logic [CW-1:0]    col_count_ff;
   logic [CW-1:0]    col_count_in;
   logic             bank_select_ff;
   logic             bank_select_in;
   logic             draining_ff;
   logic             draining_in;
   logic [PIXEL_BITS-1:0] left_pixel_ff;
   logic [PIXEL_BITS-1:0] left_pixel_in;

   // Effective geometry and the current column.
   logic [WW-1:0]       cfg_width;
   logic [WW-1:0]       eff_width;
   logic [WW-1:0]       width_m1;
   logic [HEIGHT_W-1:0] eff_height;
   logic [CW-1:0]       col_cur;
   logic [CW-1:0]       col_nxt;
   logic [CW-1:0]       col_right;
   logic                last_col;
   logic [ROW_W-1:0]    row_inc;

   assign cfg_width = WW'(image_width_ff);

   always_comb begin
      if (image_width_ff == '0) begin
         eff_width = WW'(1);
      end else if (cfg_width > WW'(MAX_WIDTH)) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = cfg_width;
      end
   end

   assign width_m1   = eff_width - WW'(1);
   assign eff_height = (image_height_ff == '0) ? HEIGHT_W'(1) : image_height_ff;
   assign col_cur    = (WW'(col_count_ff) >= eff_width) ? width_m1[CW-1:0] : col_count_ff;
   assign last_col   = (WW'(col_cur) + WW'(1)) >= eff_width;
   assign col_nxt    = col_cur + CW'(1);
   assign col_right  = last_col ? col_cur : col_nxt;
   assign row_inc    = row_count_ff + ROW_W'(1);

   // Input side.
   command_type command;
   logic        accept;
   logic        take_pixel;
   logic        take_drain;
   logic        emits;
   logic        s1_adv;

   logic s1_valid_ff;
   logic s1_valid_in;

   assign command    = command_type'(req_command);
   assign req_ready  = !s1_valid_ff || s1_adv;
   assign accept     = req_valid && req_ready;
   assign take_pixel = accept && (command == CMD_PIXEL) && !draining_ff;
   assign take_drain = accept && (command == CMD_DRAIN) && draining_ff;
   assign emits      = (take_pixel && (row_count_ff != '0)) || take_drain;

   always_comb begin
      row_count_in   = row_count_ff;
      col_count_in   = col_count_ff;
      bank_select_in = bank_select_ff;
      draining_in    = draining_ff;
      if (take_pixel) begin
         if (last_col) begin
            col_count_in   = '0;
            bank_select_in = !bank_select_ff;
            row_count_in   = row_inc;
            if (row_inc >= eff_height || row_inc == '0) begin
               draining_in = 1'b1;
            end
         end else begin
            col_count_in = col_nxt;
         end
      end else if (take_drain) begin
         if (last_col) begin
            row_count_in = '0;
            col_count_in = '0;
            draining_in  = 1'b0;
         end else begin
            col_count_in = col_nxt;
         end
      end
   end

   // Line store: both banks read at the beat, the older row rewritten in place.
   logic [PIXEL_BITS-1:0] e_rd;
   logic [PIXEL_BITS-1:0] f_rd;
   logic [PIXEL_BITS-1:0] b_rd;

   s2x_line_store #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (PIXEL_BITS)
   ) u_line_store (
      .clock     (clock),
      .rd_en     (accept),
      .rd_bank   (bank_select_ff),
      .rd_addr_e (col_cur),
      .rd_addr_f (col_right),
      .wr_en     (take_pixel),
      .wr_addr   (col_cur),
      .wr_data   (req_pixel),
      .e_data    (e_rd),
      .f_data    (f_rd),
      .b_data    (b_rd)
   );

   // Stage one: sideband next to the line store read data.
   logic [ROW_W-1:0]      s1_row_ff;
   logic [CW-1:0]         s1_col_ff;
   logic                  s1_col_nz_ff;
   logic                  s1_above_ff;
   logic                  s1_drain_ff;
   logic                  s1_last_ff;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_ff    <= row_count_ff - ROW_W'(1);
         s1_col_ff    <= col_cur;
         s1_col_nz_ff <= (col_cur != '0);
         s1_above_ff  <= (row_count_ff >= ROW_W'(2));
         s1_drain_ff  <= take_drain;
         s1_last_ff   <= take_drain && last_col;
         s1_pixel_ff  <= req_pixel;
      end
   end

   // Scale2x rules.
   logic [PIXEL_BITS-1:0] pix_b;
   logic [PIXEL_BITS-1:0] pix_d;
   logic [PIXEL_BITS-1:0] pix_e;
   logic [PIXEL_BITS-1:0] pix_f;
   logic [PIXEL_BITS-1:0] pix_h;
   logic [PIXEL_BITS-1:0] top_left_in;
   logic [PIXEL_BITS-1:0] top_right_in;
   logic [PIXEL_BITS-1:0] bottom_left_in;
   logic [PIXEL_BITS-1:0] bottom_right_in;
   logic [CXW-1:0]        src_col_ext;

   assign pix_e = e_rd;
   assign pix_f = f_rd;
   assign pix_b = s1_above_ff ? b_rd : e_rd;
   assign pix_d = s1_col_nz_ff ? left_pixel_ff : e_rd;
   assign pix_h = s1_drain_ff ? e_rd : s1_pixel_ff;

   assign top_left_in     = (pix_d == pix_b && pix_b != pix_f && pix_d != pix_h) ? pix_d : pix_e;
   assign top_right_in    = (pix_b == pix_f && pix_b != pix_d && pix_f != pix_h) ? pix_f : pix_e;
   assign bottom_left_in  = (pix_d == pix_h && pix_d != pix_b && pix_h != pix_f) ? pix_d : pix_e;
   assign bottom_right_in = (pix_h == pix_f && pix_d != pix_h && pix_b != pix_f) ? pix_f : pix_e;
   assign src_col_ext     = CXW'(s1_col_ff);

   assign s1_adv        = s1_valid_ff && (!rsp_valid || rsp_ready);
   assign left_pixel_in = !s1_adv ? left_pixel_ff : (s1_last_ff ? '0 : pix_e);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (emits) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // Output register.
   logic rsp_valid_ff;
   logic rsp_valid_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   logic [ROW_W-1:0]      rsp_src_row_ff;
   logic [COL_W-1:0]      rsp_src_col_ff;
   logic [PIXEL_BITS-1:0] rsp_top_left_ff;
   logic [PIXEL_BITS-1:0] rsp_top_right_ff;
   logic [PIXEL_BITS-1:0] rsp_bottom_left_ff;
   logic [PIXEL_BITS-1:0] rsp_bottom_right_ff;
   logic                  rsp_frame_end_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_src_row_ff      <= s1_row_ff;
         rsp_src_col_ff      <= src_col_ext[COL_W-1:0];
         rsp_top_left_ff     <= top_left_in;
         rsp_top_right_ff    <= top_right_in;
         rsp_bottom_left_ff  <= bottom_left_in;
         rsp_bottom_right_ff <= bottom_right_in;
         rsp_frame_end_ff    <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
         row_count_ff    <= '0;
         col_count_ff    <= '0;
         bank_select_ff  <= 1'b0;
         draining_ff     <= 1'b0;
         left_pixel_ff   <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         row_count_ff    <= row_count_in;
         col_count_ff    <= col_count_in;
         bank_select_ff  <= bank_select_in;
         draining_ff     <= draining_in;
         left_pixel_ff   <= left_pixel_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_src_row      = rsp_src_row_ff;
   assign rsp_src_col      = rsp_src_col_ff;
   assign rsp_top_left     = rsp_top_left_ff;
   assign rsp_top_right    = rsp_top_right_ff;
   assign rsp_bottom_left  = rsp_bottom_left_ff;
   assign rsp_bottom_right = rsp_bottom_right_ff;
   assign rsp_frame_end    = rsp_frame_end_ff;

endmodule

`default_nettype wire

FILE: rtl/core/s2x_checker.sv
`default_nettype none

module s2x_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [s2x_pkg::ROW_W-1:0]   rsp_src_row,
   input wire logic [s2x_pkg::COL_W-1:0]   rsp_src_col,
   input wire logic                        rsp_frame_end
);

   import s2x_pkg::*;

   // A stalled result beat keeps its position and flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_src_row)
         && $stable(rsp_src_col) && $stable(rsp_frame_end))
      else $error("stalled result beat changed");

   // No result beat is shown in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // A new result beat comes from an input beat held in stage one.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result beat without a matching input beat");

   // The input is never held off while no result beat is waiting.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input held off with the output empty");

endmodule

bind scale2x_pixel_upscaler s2x_checker u_s2x_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_src_row   (rsp_src_row),
   .rsp_src_col   (rsp_src_col),
   .rsp_frame_end (rsp_frame_end)
);

`default_nettype wire
